// ----- rtl/core/lpbg_pkg.sv -----
package lpbg_pkg;

	// Chain geometry
	localparam int IC_COUNT  = 32;
	localparam int SLOT_TOP  = 255;
	localparam int LED_COUNT = 170;

	localparam int LANES    = 16;
	localparam int LANE_W   = 4;
	localparam int CHANNELS = IC_COUNT * LANES;
	localparam int IC_W     = (IC_COUNT > 1) ? $clog2(IC_COUNT) : 1;
	localparam int ROW_W    = IC_W + 1;
	localparam int ROWS     = 2 ** ROW_W;
	localparam int CH_W     = 11;

	localparam logic [15:0] ALL_OFF = 16'hFFFF;

	// Command codes
	localparam logic [1:0] CMD_LOAD   = 2'd0;
	localparam logic [1:0] CMD_COMMIT = 2'd1;
	localparam logic [1:0] CMD_FETCH  = 2'd2;

	typedef logic [7:0]       level_t;
	typedef logic [ROW_W-1:0] row_addr_t;

endpackage

// ----- rtl/core/led_pwm_bitplane_generator.sv -----
// A fetch reads its row into the stage 1 registers and its word then into the
// result register, which drives the result ports, strobed by valid for one cycle.
// Throughput: one command per cycle while busy is low; the receiver cannot stall
// the result strobe. Reset: arst_n clears control state at once; busy then stays
// high while a clearing pass zeroes all ROWS rows (64 with 32 driver ICs) of both
// banks, one row per cycle. Configuration writes are taken during the pass too.
module led_pwm_bitplane_generator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  command,
	input  logic [8:0]  led_index,
	input  logic [7:0]  red,
	input  logic [7:0]  green,
	input  logic [7:0]  blue,
	input  logic [7:0]  slot,
	input  logic [5:0]  position,
	input  logic        cfg_write,
	input  logic        cfg_data,
	output logic        valid,
	output logic [15:0] word,
	output logic        frame_end,
	output logic        swapped
);

	// Brightness store: one memory per output lane (bit position within a driver
	// word), each row addressed by {bank, driver IC}. A fetch reads all sixteen
	// lanes of one row at once, which makes a 128-bit-wide read.
	lpbg_pkg::level_t mem [lpbg_pkg::LANES][lpbg_pkg::ROWS];

	logic                      color_order_q;
	logic                      front_q;
	logic                      pending_q;
	logic                      clearing_q;
	lpbg_pkg::row_addr_t       clr_row_q;

	logic                      accept;
	logic                      is_load;
	logic                      is_commit;
	logic                      is_fetch;

	// Load side
	logic                      led_ok;
	logic [lpbg_pkg::CH_W-1:0] base;
	logic [lpbg_pkg::CH_W-1:0] ch       [3];
	logic                      ch_ok    [3];
	lpbg_pkg::level_t          ch_val   [3];
	logic                      lane_we  [lpbg_pkg::LANES];
	lpbg_pkg::row_addr_t       lane_adr [lpbg_pkg::LANES];
	lpbg_pkg::level_t          lane_dat [lpbg_pkg::LANES];

	// Fetch side
	logic                      pos_ok;
	logic [lpbg_pkg::IC_W-1:0] fetch_ic;
	lpbg_pkg::row_addr_t       rd_addr;
	logic                      fend_now;
	logic                      swap_now;

	// Stage 1: registered row read and fetch attributes
	logic                      fetch_s1;
	lpbg_pkg::level_t          rd_s1    [lpbg_pkg::LANES];
	lpbg_pkg::level_t          slot_s1;
	logic                      pos_ok_s1;
	logic                      fend_s1;
	logic                      swp_s1;

	// Stage 2: result register
	logic                      valid_q;
	logic [15:0]               word_q;
	logic                      frame_end_q;
	logic                      swapped_q;
	logic [15:0]               on_mask;

	// Hold off new commands only while the clearing pass runs.
	assign busy      = clearing_q;
	assign accept    = start && !busy;
	assign is_load   = (command == lpbg_pkg::CMD_LOAD);
	assign is_commit = (command == lpbg_pkg::CMD_COMMIT);
	assign is_fetch  = (command == lpbg_pkg::CMD_FETCH);

	// Channel 3*LED+c holds channel c of the LED; color_order picks the order.
	assign led_ok = ({1'b0, led_index} < 10'(lpbg_pkg::LED_COUNT));
	assign base   = lpbg_pkg::CH_W'({led_index, 1'b0}) + lpbg_pkg::CH_W'(led_index);

	always_comb begin
		if (color_order_q) begin
			ch_val[0] = green;
			ch_val[1] = blue;
			ch_val[2] = red;
		end else begin
			ch_val[0] = red;
			ch_val[1] = green;
			ch_val[2] = blue;
		end
		for (int j = 0; j < 3; j++) begin
			ch[j]    = base + lpbg_pkg::CH_W'(j);
			ch_ok[j] = led_ok && (ch[j] < lpbg_pkg::CH_W'(lpbg_pkg::CHANNELS));
		end
	end

	// Steer each channel write to its lane. The three channels of one LED are
	// consecutive, so they always land in three different lanes, possibly in
	// two neighboring rows. During the clearing pass every lane writes zero.
	always_comb begin
		for (int l = 0; l < lpbg_pkg::LANES; l++) begin
			lane_we[l]  = 1'b0;
			lane_adr[l] = clr_row_q;
			lane_dat[l] = '0;
			if (clearing_q) begin
				lane_we[l] = 1'b1;
			end else begin
				for (int j = 0; j < 3; j++) begin
					if (accept && is_load && ch_ok[j] &&
					    (ch[j][lpbg_pkg::LANE_W-1:0] == lpbg_pkg::LANE_W'(l))) begin
						lane_we[l]  = 1'b1;
						lane_adr[l] = {!front_q, ch[j][lpbg_pkg::LANE_W +: lpbg_pkg::IC_W]};
						lane_dat[l] = ch_val[j];
					end
				end
			end
		end
	end

	// Word position 0 addresses the last IC of the chain.
	assign pos_ok   = ({1'b0, position} < 7'(lpbg_pkg::IC_COUNT));
	assign fetch_ic = lpbg_pkg::IC_W'(lpbg_pkg::IC_COUNT - 1) - position[lpbg_pkg::IC_W-1:0];
	assign rd_addr  = {front_q, fetch_ic};
	assign fend_now = (slot == 8'(lpbg_pkg::SLOT_TOP)) &&
	                  ({1'b0, position} == 7'(lpbg_pkg::IC_COUNT - 1));
	assign swap_now = accept && is_fetch && fend_now && pending_q;

	// Write and read the store; the read uses the front bank as it was before a
	// swap caused by this same fetch.
	always_ff @(posedge clk) begin
		for (int l = 0; l < lpbg_pkg::LANES; l++) begin
			if (lane_we[l]) begin
				mem[l][lane_adr[l]] <= lane_dat[l];
			end
			if (accept && is_fetch) begin
				rd_s1[l] <= mem[l][rd_addr];
			end
		end
	end

	// Hold the fetch attributes next to the row read.
	always_ff @(posedge clk) begin
		if (accept && is_fetch) begin
			slot_s1   <= slot;
			pos_ok_s1 <= pos_ok;
			fend_s1   <= fend_now;
			swp_s1    <= swap_now;
		end
	end

	// Control state: configuration, bank selection, pending flag, clearing pass.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_order_q <= 1'b0;
			front_q       <= 1'b0;
			pending_q     <= 1'b0;
			clearing_q    <= 1'b1;
			clr_row_q     <= '0;
			fetch_s1      <= 1'b0;
			valid_q       <= 1'b0;
		end else begin
			if (cfg_write) begin
				color_order_q <= cfg_data;
			end
			// Advance the clearing pass and drop busy after the last row.
			if (clearing_q) begin
				clr_row_q <= clr_row_q + 1'b1;
				if (clr_row_q == lpbg_pkg::row_addr_t'(lpbg_pkg::ROWS - 1)) begin
					clearing_q <= 1'b0;
				end
			end
			// A load drops pending, a commit raises it, a swap consumes it.
			if (accept) begin
				if (is_load) begin
					pending_q <= 1'b0;
				end else if (is_commit) begin
					pending_q <= 1'b1;
				end else if (swap_now) begin
					pending_q <= 1'b0;
				end
			end
			if (swap_now) begin
				front_q <= !front_q;
			end
			fetch_s1 <= accept && is_fetch;
			valid_q  <= fetch_s1;
		end
	end

	// Threshold compare: a channel is on while its level reaches the slot; the
	// driver wants the on-bits inverted.
	always_comb begin
		for (int k = 0; k < lpbg_pkg::LANES; k++) begin
			on_mask[k] = (rd_s1[k] >= slot_s1);
		end
	end

	always_ff @(posedge clk) begin
		if (fetch_s1) begin
			word_q      <= pos_ok_s1 ? ~on_mask : lpbg_pkg::ALL_OFF;
			frame_end_q <= fend_s1;
			swapped_q   <= swp_s1;
		end
	end

	assign valid     = valid_q;
	assign word      = word_q;
	assign frame_end = frame_end_q;
	assign swapped   = swapped_q;

endmodule

// ----- rtl/core/lpbg_checker.sv -----
module lpbg_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic [1:0]  command,
	input logic        valid,
	input logic        frame_end,
	input logic        swapped
);

	// Every accepted fetch gives one result, through the stage 1 and result registers.
	a_fetch_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && command == lpbg_pkg::CMD_FETCH) |=> ##1 valid)
		else $error("fetch transfer gave no result");

	// Anything else accepted gives no result.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && command != lpbg_pkg::CMD_FETCH) |=> ##1 !valid)
		else $error("result without a fetch transfer");

	// A bank swap only happens on the last word of a frame.
	a_swap_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && swapped) |-> frame_end)
		else $error("bank swap outside frame end");

	// Once the clearing pass is over, busy stays low.
	a_busy_once: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |=> !busy)
		else $error("busy raised after clearing pass");

endmodule

bind led_pwm_bitplane_generator lpbg_checker u_lpbg_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.command   (command),
	.valid     (valid),
	.frame_end (frame_end),
	.swapped   (swapped)
);
